>>> sv/tdlc_pkg.sv
// Shared types and constants of the TSO descriptor limit checker.
package tdlc_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MAX_DATA_DESCS   = 1'b0;
    localparam t_cfg_idx CFG_MAX_BUFFER_BYTES = 1'b1;

    localparam logic [3:0]  MAX_DATA_DESCS_RST   = 4'd10;
    localparam logic [15:0] MAX_BUFFER_BYTES_RST = 16'd16383;
    localparam logic [3:0]  DESC_COUNT_SAT       = 4'd15;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic check;
        logic div_load;
        logic emit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

>>> sv/tdlc_in_if.sv
// Input channel: one buffer segment per beat.
interface tdlc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] seg_len;
    logic        first_seg;
    logic        last_seg;
    logic [9:0]  hdr_bytes;
    logic [15:0] mss;
    logic        is_tso;
    logic [9:0]  total_descs;

    modport source (
        output valid, seg_len, first_seg, last_seg, hdr_bytes, mss, is_tso, total_descs,
        input  ready
    );
    modport sink (
        input  valid, seg_len, first_seg, last_seg, hdr_bytes, mss, is_tso, total_descs,
        output ready
    );
endinterface

>>> sv/tdlc_out_if.sv
// Output channel: one fit flag per packet.
interface tdlc_out_if;
    logic valid;
    logic ready;
    logic fits;

    modport source (output valid, fits, input ready);
    modport sink (input valid, fits, output ready);
endinterface

>>> sv/tdlc_rem_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module tdlc_rem_div #(
    parameter int unsigned W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_rem
);

    localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_shift;

    logic [W:0]   w_trial;
    logic [W:0]   w_diff;
    logic [W-1:0] n_rem;

    assign w_trial = {r_rem, r_shift[W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    // borrow out means the trial stays
    assign n_rem   = w_diff[W] ? w_trial[W-1:0] : w_diff[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < i_divisor))
        else $error("remainder not below divisor");

    a_no_restart_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");

endmodule

>>> sv/tdlc_dpath.sv
// Datapath: config registers, segment tracking state, remainder units, result register.
module tdlc_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  tdlc_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic [15:0]           i_seg_len,
    input  logic                  i_first_seg,
    input  logic                  i_last_seg,
    input  logic [9:0]            i_hdr_bytes,
    input  logic [15:0]           i_mss,
    input  logic                  i_is_tso,
    input  logic [9:0]            i_total_descs,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_fits,
    input  tdlc_pkg::t_ctrl_cmd   i_cmd,
    output tdlc_pkg::t_dp_status  o_status
);

    // configuration
    logic [3:0]  r_max_descs;
    logic [15:0] r_max_buf;

    // tracking state
    logic [3:0]  r_desc;
    logic [15:0] r_off;
    logic        r_failed;

    // captured beat
    logic [15:0] r_len;
    logic [15:0] r_seg_len;
    logic [15:0] r_mss;
    logic        r_last;
    logic        r_tso;
    logic [9:0]  r_total;

    // result register
    logic r_out_valid;
    logic r_fits;

    logic [15:0] n_len;
    logic [15:0] w_hdr;
    logic [15:0] w_buf_div;
    logic        w_skip;
    logic [16:0] w_remain;
    logic        w_limit;
    logic        w_wrap;
    logic        w_start;
    logic        w_done_a;
    logic        w_done_b;
    logic [15:0] w_rem_a;
    logic [15:0] w_rem_b;
    logic [3:0]  n_desc_wrap;
    logic        w_out_free;

    assign w_hdr = {6'd0, i_hdr_bytes};
    // saturate payload of the first segment at zero
    assign n_len = i_first_seg ? ((i_seg_len > w_hdr) ? i_seg_len - w_hdr : 16'd0)
                               : i_seg_len;

    assign w_buf_div = (r_max_buf == 16'd0) ? 16'd1 : r_max_buf;
    assign w_skip    = !r_tso || r_failed || (r_len == 16'd0);
    assign w_remain  = {1'b0, r_mss} - {1'b0, r_off};
    assign w_limit   = !w_skip && (r_desc == r_max_descs) && (w_remain != 17'd0);
    assign w_wrap    = !w_skip && !w_limit && ($signed(w_remain) < $signed({1'b0, r_len}));
    assign w_start   = i_cmd.check && w_wrap;

    assign n_desc_wrap = 4'd1 + {3'd0, (w_rem_a != 16'd0)}
                       + {3'd0, ((w_rem_b != 16'd0) && (w_rem_b < w_rem_a))};

    assign w_out_free = !r_out_valid || i_out_ready;

    tdlc_rem_div #(.W(16)) u_div_mss (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_len),
        .i_divisor  (r_mss),
        .o_done     (w_done_a),
        .o_rem      (w_rem_a)
    );

    tdlc_rem_div #(.W(16)) u_div_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_seg_len),
        .i_divisor  (w_buf_div),
        .o_done     (w_done_b),
        .o_rem      (w_rem_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_descs <= tdlc_pkg::MAX_DATA_DESCS_RST;
            r_max_buf   <= tdlc_pkg::MAX_BUFFER_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tdlc_pkg::CFG_MAX_DATA_DESCS:   r_max_descs <= i_cfg_data[3:0];
                tdlc_pkg::CFG_MAX_BUFFER_BYTES: r_max_buf   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc   <= '0;
            r_off    <= '0;
            r_failed <= 1'b0;
        end else if (i_cmd.capture) begin
            if (i_first_seg) begin
                r_desc   <= 4'd1;
                r_off    <= '0;
                r_failed <= 1'b0;
            end
        end else if (i_cmd.check) begin
            if (w_limit) begin
                r_failed <= 1'b1;
            end else if (!w_skip && !w_wrap) begin
                r_off  <= r_off + r_len;
                r_desc <= (r_desc == tdlc_pkg::DESC_COUNT_SAT) ? r_desc : r_desc + 4'd1;
            end
        end else if (i_cmd.div_load) begin
            r_off  <= w_rem_a;
            r_desc <= n_desc_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_len     <= n_len;
            r_seg_len <= i_seg_len;
            r_mss     <= (i_mss == 16'd0) ? 16'd1 : i_mss;
            r_last    <= i_last_seg;
            r_tso     <= i_is_tso;
            r_total   <= i_total_descs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_fits <= r_tso ? !r_failed : (r_total <= {6'd0, r_max_descs});
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fits            = r_fits;
    assign o_status.need_div = w_wrap;
    assign o_status.div_done = w_done_a && w_done_b;
    assign o_status.last     = r_last;
    assign o_status.out_free = w_out_free;

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken beat");

    a_limit_sets_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.check && w_limit) |=> r_failed)
        else $error("limit hit did not mark the packet failed");

    a_offset_below_mss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |=> (r_off < r_mss))
        else $error("offset after wrap not below mss");

endmodule

>>> sv/tdlc_ctrl.sv
// Controller: sequences capture, check, remainder wait and, on a last segment, result write per beat.
module tdlc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output tdlc_pkg::t_ctrl_cmd   o_cmd,
    input  tdlc_pkg::t_dp_status  i_status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                // on the last segment, hold until the result register frees up
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_one_beat_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while one is in flight");

    a_emit_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.last)
        else $error("result written for a non-last segment");

    a_div_load_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_load |-> $past(r_state == S_CHECK || r_state == S_DIV))
        else $error("remainder loaded without a divide");

endmodule

>>> sv/tso_descriptor_limit_checker_unit.sv
// TSO descriptor limit checker: top level.
//
// The input channel takes a packet one buffer segment per beat. first_seg
// opens a packet, last_seg closes it. For TSO segments the block follows
// the payload through mss-sized pieces, counting data descriptors per piece;
// non-TSO packets only compare total_descs with the limit. The output
// channel carries one fits beat per packet, on its last segment.
// The configuration port writes max_data_descs (index 0) or
// max_buffer_bytes (index 1); write only while the block is idle.
//
// One segment is taken at a time. Each passes through capture and check,
// then the result write on a last segment; a segment that crosses a TSO
// segment boundary also waits while two 16-step remainder units (offset
// within mss and offset within the buffer limit) run side by side.
// Reset clears tracking state, restores the register defaults and empties
// the result register. While the receiver stalls a finished result waits
// in the result register; the next segment is still accepted and worked
// on, and only its own result write waits for the register to free up.
module tso_descriptor_limit_checker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  tdlc_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    tdlc_in_if.sink            i_in,
    tdlc_out_if.source         o_out
);

    tdlc_pkg::t_ctrl_cmd  w_cmd;
    tdlc_pkg::t_dp_status w_status;

    tdlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    tdlc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_seg_len     (i_in.seg_len),
        .i_first_seg   (i_in.first_seg),
        .i_last_seg    (i_in.last_seg),
        .i_hdr_bytes   (i_in.hdr_bytes),
        .i_mss         (i_in.mss),
        .i_is_tso      (i_in.is_tso),
        .i_total_descs (i_in.total_descs),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_fits        (o_out.fits),
        .i_cmd         (w_cmd),
        .o_status      (w_status)
    );

endmodule
